// ===== hdl/rc5_pkg.sv =====
// ----------------------------------------------------------------------------
// RC5 package
// Shared constants, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none
package rc5_pkg;
    localparam int unsigned MAX_ROUNDS_DEF    = 32;
    localparam int unsigned MAX_KEY_BYTES_DEF = 255;
    localparam int unsigned KEY_DEPTH         = 64;
    localparam int unsigned KEY_AW            = 6;
    localparam logic [31:0] MAGIC_P           = 32'hB7E15163;
    localparam logic [31:0] MAGIC_Q           = 32'h9E3779B9;
    localparam logic [5:0]  DEFAULT_ROUNDS    = 6'd12;

    localparam logic [1:0] ACT_KEY = 2'd0;
    localparam logic [1:0] ACT_ENC = 2'd1;
    localparam logic [1:0] ACT_DEC = 2'd2;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,  // latch block, reset indices
        OP_KCLR    = 4'd2,  // clear one key word
        OP_KBYTE   = 4'd3,  // merge one key byte
        OP_SINIT   = 4'd4,  // write one initial subkey
        OP_MIXRD   = 4'd5,  // read S[i], L[j]
        OP_MIXA    = 4'd6,  // compute a, write S[i]
        OP_MIXB    = 4'd7,  // compute b, write L[j]
        OP_ENCRD   = 4'd8,  // read next subkey
        OP_ENC     = 4'd9,  // encrypt half-round
        OP_DEC     = 4'd10, // decrypt half-round
        OP_NOKEY   = 4'd11  // result block zero
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] idx;    // sweep / subkey index
        logic       first;  // first step of a mix or cipher sequence
    } dp_cmd_t;
endpackage
`default_nettype wire

// ===== hdl/rc5_datapath.sv =====
// ----------------------------------------------------------------------------
// RC5 datapath
// Key word store, subkey store, mixing and round arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
module rc5_datapath
    import rc5_pkg::*;
#(
    parameter int unsigned MAX_ROUNDS = MAX_ROUNDS_DEF
) (
    input  wire logic        clk,
    input  wire dp_cmd_t     cmd,
    input  wire logic [7:0]  kpos,
    input  wire logic [7:0]  key_byte,
    input  wire logic [63:0] blk,
    input  wire logic [KEY_AW-1:0] kc_m1,
    output logic [63:0]      result
);
    localparam int unsigned SK_DEPTH = 2 * (MAX_ROUNDS + 1);
    localparam int unsigned SK_AW    = $clog2(SK_DEPTH);

    logic [31:0] key_mem [KEY_DEPTH];
    logic [31:0] sk_mem  [SK_DEPTH];
    logic [31:0] a_reg, b_reg, s_reg, l_reg, sinit_reg;
    logic [KEY_AW-1:0] j_reg;
    logic [31:0] kb_rd_reg;
    logic [31:0] a_new, b_new, sum_b, d_b, d_a;

    // rotate helpers
    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} << n;
        return w[63:32];
    endfunction
    function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} >> n;
        return w[31:0];
    endfunction

    assign a_new = rotl(s_reg + a_reg + b_reg, 5'd3);
    assign sum_b = a_reg + b_reg;
    assign b_new = rotl(l_reg + sum_b, sum_b[4:0]);
    assign d_b   = rotr(b_reg - s_reg, a_reg[4:0]) ^ a_reg;
    assign d_a   = rotr(a_reg - s_reg, b_reg[4:0]) ^ b_reg;

    // key store: read-modify-write for byte merge uses registered read
    always_ff @(posedge clk)
    begin
        kb_rd_reg <= key_mem[kpos[KEY_AW+1:2]];
        unique case (cmd.op)
            OP_KCLR:  key_mem[cmd.idx[KEY_AW-1:0]] <= '0;
            OP_KBYTE: key_mem[kpos[KEY_AW+1:2]] <=
                          kb_rd_reg | ({24'd0, key_byte} << {kpos[1:0], 3'd0});
            OP_MIXB:  key_mem[j_reg] <= b_new;
            default:  ;
        endcase
        l_reg <= key_mem[j_reg];
    end

    // subkey store
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_SINIT: sk_mem[cmd.idx[SK_AW-1:0]] <= sinit_reg;
            OP_MIXA:  sk_mem[cmd.idx[SK_AW-1:0]] <= a_new;
            default:  ;
        endcase
        s_reg <= sk_mem[cmd.idx[SK_AW-1:0]];
    end

    // working words
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                a_reg <= blk[31:0];
                b_reg <= blk[63:32];
                j_reg <= '0;
                sinit_reg <= MAGIC_P;
            end
            OP_SINIT: sinit_reg <= sinit_reg + MAGIC_Q;
            OP_MIXRD: if (cmd.first) begin a_reg <= '0; b_reg <= '0; end
            OP_MIXA:  a_reg <= a_new;
            OP_MIXB:
            begin
                b_reg <= b_new;
                j_reg <= (j_reg == kc_m1) ? '0 : j_reg + 1'b1;
            end
            OP_ENC:
            begin
                // even index updates A, odd index updates B
                if (cmd.first && !cmd.idx[0])
                    a_reg <= a_reg + s_reg;
                else if (!cmd.idx[0])
                    a_reg <= rotl(a_reg ^ b_reg, b_reg[4:0]) + s_reg;
                if (cmd.first && cmd.idx[0])
                    b_reg <= b_reg + s_reg;
                else if (cmd.idx[0] && !cmd.first)
                    b_reg <= rotl(b_reg ^ a_reg, a_reg[4:0]) + s_reg;
            end
            OP_DEC:
            begin
                if (cmd.first)
                begin
                    if (cmd.idx[0]) b_reg <= b_reg - s_reg;
                    else            a_reg <= a_reg - s_reg;
                end
                else if (cmd.idx[0]) b_reg <= d_b;
                else                 a_reg <= d_a;
            end
            OP_NOKEY: begin a_reg <= '0; b_reg <= '0; end
            default: ;
        endcase
    end

    assign result = {b_reg, a_reg};
endmodule
`default_nettype wire

// ===== hdl/rc5_control.sv =====
// ----------------------------------------------------------------------------
// RC5 controller
// Sequences key clearing, byte loading, expansion and cipher rounds.
// ----------------------------------------------------------------------------
`default_nettype none
module rc5_control
    import rc5_pkg::*;
#(
    parameter int unsigned MAX_ROUNDS    = MAX_ROUNDS_DEF,
    parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic        key_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output dp_cmd_t          cmd,
    output logic [7:0]       kpos,
    output logic [KEY_AW-1:0] kc_m1
);
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_KCLR  = 10'b0000000010,
        ST_KRD   = 10'b0000000100,
        ST_KWR   = 10'b0000001000,
        ST_SINIT = 10'b0000010000,
        ST_MRD   = 10'b0000100000,
        ST_MA    = 10'b0001000000,
        ST_MB    = 10'b0010000000,
        ST_CRD   = 10'b0100000000,
        ST_CRUN  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] rounds_reg, act_rounds_reg, eff_r;
    logic [7:0] kcnt_reg, kcnt_next, idx_reg, idx_next, t_m1;
    logic [9:0] pass_reg, pass_next, passes;
    logic       ready_reg, ready_next, last_reg, last_next, dec_reg, dec_next;
    logic       ov_reg, ov_next, st_reg, st_next, first_reg, first_next;
    logic [7:0] c_words;

    // effective round count from the register
    always_comb
    begin
        eff_r = (rounds_reg == 6'd0) ? DEFAULT_ROUNDS : rounds_reg;
        if (32'(eff_r) > MAX_ROUNDS) eff_r = 6'(MAX_ROUNDS);
    end
    assign t_m1    = {eff_r, 1'b0} + 8'd1;
    assign c_words = (kcnt_reg == 8'd0) ? 8'd1 : 8'((9'(kcnt_reg) + 9'd3) >> 2);
    assign kc_m1   = KEY_AW'(c_words - 8'd1);
    assign passes  = (t_m1 + 8'd1 > c_words) ? 10'(3 * (t_m1 + 8'd1)) : 10'(3 * c_words);
    assign kpos    = kcnt_reg;

    assign in_ready  = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign status    = st_reg;

    always_comb
    begin
        state_next = state_reg;
        kcnt_next  = kcnt_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        ready_next = ready_reg;
        last_next  = last_reg;
        dec_next   = dec_reg;
        ov_next    = ov_reg && !out_ready;
        st_next    = st_reg;
        first_next = first_reg;
        cmd        = '{op: OP_NONE, idx: idx_reg, first: first_reg};
        unique case (state_reg)
            ST_IDLE:
            if (in_valid && in_ready)
            begin
                last_next = key_last;
                if (action == ACT_KEY)
                begin
                    idx_next = '0;
                    state_next = (kcnt_reg == 8'd0) ? ST_KCLR : ST_KRD;
                end
                else if (action == ACT_ENC || action == ACT_DEC)
                begin
                    if (!ready_reg)
                    begin
                        cmd.op = OP_NOKEY;
                        ov_next = 1'b1;
                        st_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op = OP_LOAD;
                        dec_next = (action == ACT_DEC);
                        first_next = 1'b1;
                        idx_next = (action == ACT_DEC) ? {act_rounds_reg, 1'b0} + 8'd1 : 8'd0;
                        state_next = ST_CRD;
                    end
                end
            end
            ST_KCLR:
            begin
                cmd.op = OP_KCLR;
                idx_next = idx_reg + 8'd1;
                if (idx_reg == 8'(KEY_DEPTH - 1)) state_next = ST_KRD;
            end
            ST_KRD: state_next = ST_KWR;
            ST_KWR:
            begin
                if (32'(kcnt_reg) < MAX_KEY_BYTES)
                begin
                    cmd.op = OP_KBYTE;
                    kcnt_next = kcnt_reg + 8'd1;
                end
                state_next = last_reg ? ST_SINIT : ST_IDLE;
                idx_next = '0;
            end
            ST_SINIT:
            begin
                // kcnt already updated; sinit register starts at P after a load
                cmd.op = (idx_reg == 8'd0) ? OP_LOAD : OP_SINIT;
                if (idx_reg != 8'd0) cmd.idx = idx_reg - 8'd1;
                idx_next = idx_reg + 8'd1;
                if (idx_reg == t_m1 + 8'd1)
                begin
                    idx_next = '0;
                    pass_next = '0;
                    first_next = 1'b1;
                    state_next = ST_MRD;
                end
            end
            ST_MRD:
            begin
                cmd.op = OP_MIXRD;
                first_next = 1'b0;
                state_next = ST_MA;
            end
            ST_MA:
            begin
                cmd.op = OP_MIXA;
                state_next = ST_MB;
            end
            ST_MB:
            begin
                cmd.op = OP_MIXB;
                idx_next = (idx_reg == t_m1) ? 8'd0 : idx_reg + 8'd1;
                pass_next = pass_reg + 10'd1;
                if (pass_reg == passes - 10'd1)
                begin
                    ready_next = 1'b1;
                    kcnt_next = '0;
                    state_next = ST_IDLE;
                end
                else state_next = ST_MRD;
            end
            ST_CRD: state_next = ST_CRUN;
            ST_CRUN:
            begin
                cmd.op = dec_reg ? OP_DEC : OP_ENC;
                if (dec_reg)
                    cmd.first = (idx_reg < 8'd2);
                else
                    cmd.first = (idx_reg < 8'd2);
                first_next = 1'b0;
                if ((!dec_reg && idx_reg == {act_rounds_reg, 1'b0} + 8'd1) ||
                    (dec_reg && idx_reg == 8'd0))
                begin
                    ov_next = 1'b1;
                    st_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = dec_reg ? idx_reg - 8'd1 : idx_reg + 8'd1;
                    state_next = ST_CRD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rounds_reg <= DEFAULT_ROUNDS;
            act_rounds_reg <= DEFAULT_ROUNDS;
            kcnt_reg <= '0;
            ready_reg <= 1'b0;
            ov_reg <= 1'b0;
            idx_reg <= '0;
            pass_reg <= '0;
            last_reg <= 1'b0;
            dec_reg <= 1'b0;
            st_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) rounds_reg <= cfg_data;
            if (state_reg == ST_MB && state_next == ST_IDLE) act_rounds_reg <= eff_r;
            kcnt_reg <= kcnt_next;
            ready_reg <= ready_next;
            ov_reg <= ov_next;
            idx_reg <= idx_next;
            pass_reg <= pass_next;
            last_reg <= last_next;
            dec_reg <= dec_next;
            st_reg <= st_next;
            first_reg <= first_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/rc5_block_cipher.sv =====
// ----------------------------------------------------------------------------
// RC5-32 block cipher
// Key loading, key expansion and block encrypt/decrypt with valid/ready.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one item: a key byte
// (action 0) or a block to encrypt (1) or decrypt (2). A key byte item passes
// through the accepting cycle, a key word read and the byte merge; the first
// byte of a key also clears the 64-word key store. The byte with key_last set
// starts key expansion: table init writes the 2r+2 subkeys, then each mix
// step reads, computes a and computes b, over 3*max(2r+2, c) steps. For a
// block the controller reads each of the 2r+2 subkeys and then applies it;
// the result is valid once the last one is applied. The result sits in an
// output register (out_valid/out_ready); no new item is taken while it
// waits. A block before any key gives status 1 and a zero block. Reset
// clears control state and sets rounds to 12; the stores are not cleared.
// The user must write rounds through cfg_we/cfg_data only while idle; the
// block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module rc5_block_cipher
    import rc5_pkg::*;
#(
    parameter int unsigned MAX_ROUNDS    = MAX_ROUNDS_DEF,
    parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  key_byte,
    input  wire logic        key_last,
    input  wire logic [63:0] block_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      block_out,
    output logic             status
);
    dp_cmd_t cmd;
    logic [7:0] kpos;
    logic [7:0] kbyte_reg;
    logic [KEY_AW-1:0] kc_m1;

    // hold key byte for the merge step
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) kbyte_reg <= key_byte;
    end

    rc5_control #(.MAX_ROUNDS(MAX_ROUNDS), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_ctrl (
        .clk, .rst_n, .cfg_we, .cfg_data, .in_valid, .in_ready, .action,
        .key_last, .out_valid, .out_ready, .status, .cmd, .kpos, .kc_m1
    );

    rc5_datapath #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
        .clk, .cmd, .kpos, .key_byte(kbyte_reg), .blk(block_in), .kc_m1,
        .result(block_out)
    );
endmodule
`default_nettype wire

// ===== tb/tb_rc5_block_cipher.sv =====
// ----------------------------------------------------------------------------
// RC5-32 block cipher testbench
// Loads keys byte by byte, encrypts and decrypts blocks under several round
// settings and checks every result block against an in-bench cipher model,
// with random gaps and stalls on both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rc5_block_cipher;
    import rc5_pkg::*;

    localparam int unsigned ACC_LIMIT = 200000;
    localparam int unsigned TAIL_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ACT_KEY;
    logic [7:0]  key_byte = '0;
    logic        key_last = 1'b0;
    logic [63:0] block_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] block_out;
    logic        status;

    rc5_block_cipher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .key_byte (key_byte),
        .key_last (key_last),
        .block_in (block_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .block_out(block_out),
        .status   (status)
    );

    always #6 clk = ~clk;

    // cipher state held by the bench
    typedef struct packed {
        logic [63:0] blk;
        logic        st;
    } cipher_res_t;

    logic [31:0] key_store [KEY_DEPTH];
    logic [31:0] sub_keys [2*(MAX_ROUNDS_DEF+1)];
    int unsigned bytes_held;
    bit          have_key;
    logic [5:0]  rounds_reg;
    int unsigned rounds_latched;

    cipher_res_t expected_blocks[$];
    int unsigned n_mismatch;
    int unsigned n_results;
    int unsigned n_items;
    int unsigned n_keys;
    int unsigned idle_cycles;
    bit          long_stall;

    function automatic logic [31:0] rol(input logic [31:0] v, input logic [31:0] n);
        logic [4:0] s;
        s = n[4:0];
        return (v << s) | (v >> (6'd32 - s));
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] v, input logic [31:0] n);
        logic [4:0] s;
        s = n[4:0];
        return (v >> s) | (v << (6'd32 - s));
    endfunction

    task automatic expand_subkeys(input int unsigned nbytes);
        int unsigned r, t, c, passes, i, j;
        logic [31:0] a, b;
        r = (rounds_reg == 0) ? 12 : rounds_reg;
        if (r > MAX_ROUNDS_DEF) r = MAX_ROUNDS_DEF;
        t = 2 * (r + 1);
        c = (nbytes + 3) / 4;
        if (c == 0) c = 1;
        if (c > KEY_DEPTH) c = KEY_DEPTH;
        sub_keys[0] = MAGIC_P;
        for (int n = 1; n < t; n++) sub_keys[n] = sub_keys[n-1] + MAGIC_Q;
        passes = 3 * ((t > c) ? t : c);
        i = 0; j = 0; a = '0; b = '0;
        for (int n = 0; n < passes; n++)
        begin
            a = rol(sub_keys[i] + a + b, 3);
            sub_keys[i] = a;
            b = rol(key_store[j] + a + b, a + b);
            key_store[j] = b;
            i = (i + 1 == t) ? 0 : i + 1;
            j = (j + 1 == c) ? 0 : j + 1;
        end
        rounds_latched = r;
        have_key = 1'b1;
    endtask

    // advance the bench model by one accepted item
    task automatic cipher_predict(input logic [1:0] act, input logic [7:0] kb,
                                  input logic kl, input logic [63:0] blk);
        logic [31:0] a, b;
        cipher_res_t res;
        if (act == ACT_KEY)
        begin
            if (bytes_held == 0)
                foreach (key_store[k]) key_store[k] = '0;
            if (bytes_held < MAX_KEY_BYTES_DEF)
            begin
                key_store[(bytes_held >> 2) % KEY_DEPTH] |=
                    32'(kb) << (8 * (bytes_held % 4));
                bytes_held++;
            end
            if (kl)
            begin
                expand_subkeys(bytes_held);
                bytes_held = 0;
            end
            return;
        end
        if (act != ACT_ENC && act != ACT_DEC) return;
        if (!have_key)
        begin
            res.blk = '0;
            res.st = 1'b1;
            expected_blocks.push_back(res);
            return;
        end
        a = blk[31:0];
        b = blk[63:32];
        if (act == ACT_ENC)
        begin
            a += sub_keys[0];
            b += sub_keys[1];
            for (int i = 1; i <= rounds_latched; i++)
            begin
                a = rol(a ^ b, b) + sub_keys[2*i];
                b = rol(b ^ a, a) + sub_keys[2*i+1];
            end
        end
        else
        begin
            for (int i = rounds_latched; i >= 1; i--)
            begin
                b = ror(b - sub_keys[2*i+1], a) ^ a;
                a = ror(a - sub_keys[2*i], b) ^ b;
            end
            b -= sub_keys[1];
            a -= sub_keys[0];
        end
        res.blk = {b, a};
        res.st = 1'b0;
        expected_blocks.push_back(res);
    endtask

    // offer one item and wait for it to be taken
    task automatic send_item(input logic [1:0] act, input logic [7:0] kb,
                             input logic kl, input logic [63:0] blk);
        // previous item is still being dropped on this edge
        if (in_valid) @(negedge clk);
        action <= act;
        key_byte <= kb;
        key_last <= kl;
        block_in <= blk;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        cipher_predict(act, kb, kl, blk);
        n_items++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic sender_gap();
        int unsigned g;
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                         : $urandom_range(0, 2);
        repeat (g) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (expected_blocks.size() != 0) @(negedge clk);
        // the last item may have been a key byte still expanding
        repeat (12000) @(negedge clk);
    endtask

    task automatic write_rounds(input logic [5:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        rounds_reg = v;
    endtask

    task automatic load_key(input int unsigned len);
        for (int k = 0; k < len; k++)
        begin
            send_item(ACT_KEY, 8'($urandom), (k == len - 1), '0);
            sender_gap();
        end
        n_keys++;
    endtask

    function automatic logic [63:0] rand_block();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // directed items: action, key byte, last mark, block, typed-in result
    typedef struct {
        logic [1:0]  act;
        logic [7:0]  kb;
        logic        kl;
        logic [63:0] blk;
        bit          fixed;
        logic [63:0] res_blk;
        logic        res_st;
    } stim_row_t;

    stim_row_t directed [] = '{
        '{ACT_ENC, 8'h00, 1'b0, 64'h0,                 1, 64'h0, 1'b1},
        '{ACT_DEC, 8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0, 1'b1},
        '{2'd3,    8'h55, 1'b0, 64'h1234,              0, 64'h0, 1'b0},
        '{ACT_KEY, 8'h00, 1'b0, 64'h0,                 0, 64'h0, 1'b0},
        '{ACT_KEY, 8'hFF, 1'b0, 64'h0,                 0, 64'h0, 1'b0},
        '{ACT_KEY, 8'hA5, 1'b0, 64'h0,                 0, 64'h0, 1'b0},
        '{ACT_KEY, 8'h5A, 1'b1, 64'h0,                 0, 64'h0, 1'b0},
        '{ACT_ENC, 8'h00, 1'b0, 64'h0,                 0, 64'h0, 1'b0},
        '{ACT_ENC, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0, 1'b0},
        '{ACT_DEC, 8'h00, 1'b0, 64'h0,                 0, 64'h0, 1'b0},
        '{ACT_DEC, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0, 1'b0},
        '{2'd3,    8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0, 1'b0},
        // one-byte key, then a block while the next key is half loaded
        '{ACT_KEY, 8'h80, 1'b1, 64'h0,                 0, 64'h0, 1'b0},
        '{ACT_KEY, 8'h01, 1'b0, 64'h0,                 0, 64'h0, 1'b0},
        '{ACT_ENC, 8'h00, 1'b0, 64'h0123_4567_89AB_CDEF, 0, 64'h0, 1'b0},
        '{ACT_KEY, 8'h02, 1'b1, 64'h0,                 0, 64'h0, 1'b0},
        '{ACT_DEC, 8'h00, 1'b0, 64'h8000_0000_0000_0001, 0, 64'h0, 1'b0}
    };

    // result checker
    always @(posedge clk)
    begin
        cipher_res_t want;
        if (out_valid && out_ready)
        begin
            n_results++;
            if (expected_blocks.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result block=%h status=%b", block_out, status);
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (block_out !== want.blk || status !== want.st)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: block exp %h got %h, status exp %b got %b",
                                 want.blk, block_out, want.st, status);
                end
            end
        end
    end

    // receiver stalls, with one long hold-off on request
    initial
    begin
        int unsigned g;
        forever
        begin
            @(negedge clk);
            if (long_stall)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                long_stall = 1'b0;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                g = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 80)
                                                 : $urandom_range(1, 3);
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // watchdog on acceptance progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > ACC_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [5:0] settings [];
        int unsigned blocks;
        settings = '{6'd12, 6'd0, 6'd1, 6'd32, 6'd63, 6'd5, 6'd20};
        idle_cycles = 0;
        n_mismatch = 0; n_results = 0; n_items = 0; n_keys = 0;
        long_stall = 0;
        bytes_held = 0; have_key = 0;
        rounds_reg = DEFAULT_ROUNDS; rounds_latched = 12;
        foreach (key_store[k]) key_store[k] = '0;
        foreach (sub_keys[k]) sub_keys[k] = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (directed[d])
        begin
            if (directed[d].fixed)
            begin
                cipher_res_t f;
                send_item(directed[d].act, directed[d].kb, directed[d].kl,
                          directed[d].blk);
                f = expected_blocks[expected_blocks.size()-1];
                if (f.blk !== directed[d].res_blk || f.st !== directed[d].res_st)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("row %0d: block exp %h got %h, status exp %b got %b",
                                 d, directed[d].res_blk, f.blk, directed[d].res_st, f.st);
                end
            end
            else
                send_item(directed[d].act, directed[d].kb, directed[d].kl,
                          directed[d].blk);
        end
        wait_drained();

        // over-long key: last mark falls on an ignored byte
        load_key(260);
        for (int k = 0; k < 4; k++) send_item(ACT_ENC, 8'h00, 1'b0, rand_block());
        wait_drained();

        // random phases across round settings
        foreach (settings[s])
        begin
            write_rounds(settings[s]);
            blocks = 0;
            while (blocks < 85)
            begin
                int unsigned pick;
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    load_key($urandom_range(0, 9) == 0 ? $urandom_range(17, 64)
                                                       : $urandom_range(1, 16));
                else if (pick == 1)
                    send_item(2'd3, 8'($urandom), 1'($urandom), rand_block());
                else if (pick == 2)
                begin
                    // partial key, a block mid-key, then finish it
                    send_item(ACT_KEY, 8'($urandom), 1'b0, '0);
                    send_item(ACT_ENC, 8'h00, 1'b0, rand_block());
                    send_item(ACT_KEY, 8'($urandom), 1'b1, '0);
                    blocks++;
                end
                else
                begin
                    if (s == 3 && blocks == 40) long_stall = 1'b1;
                    send_item($urandom_range(0, 1) ? ACT_ENC : ACT_DEC,
                              8'($urandom), 1'($urandom), rand_block());
                    blocks++;
                end
                if (blocks == 60) wait_drained();
                else sender_gap();
            end
            // rounds change takes hold only with the next key
            wait_drained();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d items, %0d keys, %0d results over %0d round settings.",
                 n_items, n_keys, n_results, settings.size());
        if (n_mismatch == 0 && expected_blocks.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/rc5_pkg.sv
hdl/rc5_datapath.sv
hdl/rc5_control.sv
hdl/rc5_block_cipher.sv
tb/tb_rc5_block_cipher.sv
